// ===== hw/rtl/grc_pkg.sv =====
// Shared types and constants of the grid ray caster.
`timescale 1ns / 1ps
package grc_pkg;

    localparam int MAP_BITS    = 6;
    localparam int ADDR_BITS   = 2 * MAP_BITS;
    localparam int FRAC_BITS   = 16;
    localparam int POS_W       = 22;
    localparam int VEC_W       = 18;
    localparam int CAM_W       = 19;
    localparam int RAY_W       = 21;
    localparam int DIST_W      = 24;
    localparam int SD_W        = 33;
    localparam int DVD_W       = 33;
    localparam int LH_W        = 16;
    localparam int ROW_W       = 9;
    localparam int COL_W       = 10;
    localparam int TEX_W       = 6;
    localparam int STEP_W      = 8;
    localparam int CFG_IDX_W   = 3;

    localparam logic [POS_W-1:0] POS_RST     = 22'h210000;
    localparam logic [VEC_W-1:0] DIR_X_RST   = 18'h30000;
    localparam logic [VEC_W-1:0] DIR_Y_RST   = 18'h00000;
    localparam logic [VEC_W-1:0] PLANE_X_RST = 18'h00000;
    localparam logic [VEC_W-1:0] PLANE_Y_RST = 18'h0A8F6;

    localparam logic [DVD_W-1:0] ONE_SQ      = 33'h1_0000_0000;
    localparam logic [DVD_W-1:0] ROWS_Q16    = 33'd31457280;
    localparam logic [17:0]      CAM_MUL     = 18'd204;
    localparam logic [15:0]      FIFTH_Q16   = 16'd13108;
    localparam logic [ROW_W-1:0] HALF_ROWS   = 9'd240;
    localparam logic [ROW_W-1:0] LAST_ROW    = 9'd479;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POS_X   = 3'd0,
        REG_POS_Y   = 3'd1,
        REG_DIR_X   = 3'd2,
        REG_DIR_Y   = 3'd3,
        REG_PLANE_X = 3'd4,
        REG_PLANE_Y = 3'd5
    } cfg_reg_t;

    typedef enum logic [4:0] {
        OP_NOP, OP_CLEAR, OP_WRITE, OP_LOAD, OP_CAM, OP_RMUL, OP_RAY,
        OP_DIVX, OP_STX, OP_DIVY, OP_STY, OP_SIDE, OP_STEP, OP_LOST,
        OP_PERP, OP_DIVH, OP_STH, OP_WMUL, OP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic div_busy;
        logic at_limit;
        logic off_map;
        logic wall;
        logic out_busy;
    } dp_status_t;

endpackage

// ===== hw/rtl/grc_if.sv =====
// Handshake channel interfaces for cast requests and cast results.
`timescale 1ns / 1ps
interface grc_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [5:0] cell_x;
    logic [5:0] cell_y;
    logic       cell_wall;
    logic [9:0] column;
    modport source (output valid, kind, cell_x, cell_y, cell_wall, column, input ready);
    modport sink   (input valid, kind, cell_x, cell_y, cell_wall, column, output ready);
endinterface

interface grc_out_if;
    logic        valid;
    logic        ready;
    logic [9:0]  column_out;
    logic        hit_side;
    logic [23:0] perp_dist_q16;
    logic [15:0] slice_height;
    logic [8:0]  row_top;
    logic [8:0]  row_bottom;
    logic [5:0]  tex_column;
    logic [5:0]  hit_x;
    logic [5:0]  hit_y;
    logic        out_of_map;
    modport source (output valid, column_out, hit_side, perp_dist_q16, slice_height,
                    row_top, row_bottom, tex_column, hit_x, hit_y, out_of_map,
                    input ready);
    modport sink   (input valid, column_out, hit_side, perp_dist_q16, slice_height,
                    row_top, row_bottom, tex_column, hit_x, hit_y, out_of_map,
                    output ready);
endinterface

// ===== hw/rtl/grid_ray_caster.sv =====
// Top level of the grid ray caster: controller, datapath and ports.
//
//   channel    dir   handshake            carries
//   cast_in    in    valid/ready          kind, cell_x, cell_y, cell_wall, column
//   res_out    out   valid/ready          column_out .. out_of_map
//   cfg        in    cfg_we               cfg_index, cfg_data
//
// A cast that hits makes three divider passes (two ray deltas, line height)
// and at most 128 grid steps. A lost ray skips the height pass.
// After reset a clearing pass zeroes the wall map with ready low.
// A waiting result stalls the next cast only at its own result load.
`timescale 1ns / 1ps
module grid_ray_caster
    import grc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    grc_in_if.sink               cast_in,
    grc_out_if.source            res_out,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [POS_W-1:0]     cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t st;

    grc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cast_in.valid),
        .in_kind  (cast_in.kind),
        .in_ready (cast_in.ready),
        .status   (st),
        .cmd      (cmd)
    );

    grc_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (st),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cell_x        (cast_in.cell_x),
        .cell_y        (cast_in.cell_y),
        .cell_wall     (cast_in.cell_wall),
        .column        (cast_in.column),
        .out_ready     (res_out.ready),
        .out_valid     (res_out.valid),
        .column_out    (res_out.column_out),
        .hit_side      (res_out.hit_side),
        .perp_dist_q16 (res_out.perp_dist_q16),
        .slice_height  (res_out.slice_height),
        .row_top       (res_out.row_top),
        .row_bottom    (res_out.row_bottom),
        .tex_column    (res_out.tex_column),
        .hit_x         (res_out.hit_x),
        .hit_y         (res_out.hit_y),
        .out_of_map    (res_out.out_of_map)
    );

`ifndef SYNTHESIS
    a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        cast_in.ready |-> !st.div_busy)
        else $error("divider busy while idle");

    a_cast_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cast_in.valid && cast_in.ready && cast_in.kind) |=> !cast_in.ready)
        else $error("ready after cast transaction");

    a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_FINISH) |=> res_out.valid)
        else $error("result not presented after finish");

    a_lost_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (res_out.valid && res_out.out_of_map) |-> (res_out.perp_dist_q16 == '0))
        else $error("lost ray carries a distance");
`endif

endmodule

// ===== hw/rtl/grc_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module grc_div
    import grc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DVD_W-1:0]  dividend,
    input  logic [DIST_W-1:0] divisor,
    output logic              busy,
    output logic [DVD_W-1:0]  quotient
);

    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [DIST_W:0]   rem_reg, rem_next;
    logic [DIST_W-1:0] dvs_reg;
    logic [5:0]        cnt_reg;
    logic              busy_reg;
    logic [DIST_W:0]   rem_sh;
    logic [DIST_W+1:0] diff;

    always_comb
    begin
        rem_sh = {rem_reg[DIST_W-1:0], dvd_reg[DVD_W-1]};
        diff   = {1'b0, rem_sh} - {2'b00, dvs_reg};
        if (!diff[DIST_W+1])
        begin
            rem_next = diff[DIST_W:0];
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = rem_sh;
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 6'd1;
            if (cnt_reg == 6'(DVD_W - 1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = dvd_reg;

endmodule

// ===== hw/rtl/grc_dp.sv =====
// Datapath: camera registers, wall map, ray setup, DDA walk and result register.
`timescale 1ns / 1ps
module grc_dp
    import grc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dp_cmd_t              cmd,
    output dp_status_t           status,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [POS_W-1:0]     cfg_data,
    input  logic [MAP_BITS-1:0]  cell_x,
    input  logic [MAP_BITS-1:0]  cell_y,
    input  logic                 cell_wall,
    input  logic [COL_W-1:0]     column,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [COL_W-1:0]     column_out,
    output logic                 hit_side,
    output logic [DIST_W-1:0]    perp_dist_q16,
    output logic [LH_W-1:0]      slice_height,
    output logic [ROW_W-1:0]     row_top,
    output logic [ROW_W-1:0]     row_bottom,
    output logic [TEX_W-1:0]     tex_column,
    output logic [MAP_BITS-1:0]  hit_x,
    output logic [MAP_BITS-1:0]  hit_y,
    output logic                 out_of_map
);

    logic [POS_W-1:0]         pos_x_reg, pos_y_reg;
    logic signed [VEC_W-1:0]  dir_x_reg, dir_y_reg, plane_x_reg, plane_y_reg;

    logic                     map_mem [0:(1<<ADDR_BITS)-1];
    logic                     rd_reg;
    logic [ADDR_BITS-1:0]     clr_cnt_reg;
    logic                     we;
    logic [ADDR_BITS-1:0]     waddr, raddr;

    logic [COL_W-1:0]         column_reg;
    logic signed [CAM_W-1:0]  cam_reg;
    logic signed [CAM_W+VEC_W-1:0] prx_reg, pry_reg;
    logic signed [RAY_W-1:0]  rx_reg, ry_reg;
    logic [DIST_W-1:0]        ddx_reg, ddy_reg, perp_reg;
    logic [SD_W-1:0]          sdx_reg, sdy_reg;
    logic [MAP_BITS:0]        mx_reg, my_reg;
    logic [STEP_W-1:0]        steps_reg;
    logic                     side_reg, lost_reg;
    logic [LH_W-1:0]          lh_reg;
    logic signed [DIST_W+RAY_W:0] wprod_reg;

    logic                     div_start, div_busy;
    logic [DVD_W-1:0]         div_dvd, div_q;
    logic [DIST_W-1:0]        div_dvs;
    logic [RAY_W-1:0]         abs_rx, abs_ry;

    logic [17:0]              cam_a;
    logic [25:0]              cam_b;
    logic [CAM_W-1:0]         cam_sum;
    logic                     take_x;
    logic [MAP_BITS:0]        mx_step, my_step;
    logic [16:0]              ax, ay;
    logic [40:0]              sx_prod, sy_prod;
    logic [SD_W-1:0]          perp_diff;
    logic [FRAC_BITS-1:0]     wall_lo;
    logic [TEX_W-1:0]         tex;
    logic [ROW_W-1:0]         ds, de;
    logic [LH_W-2:0]          half;

    logic                     out_valid_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg   <= POS_RST;
            pos_y_reg   <= POS_RST;
            dir_x_reg   <= DIR_X_RST;
            dir_y_reg   <= DIR_Y_RST;
            plane_x_reg <= PLANE_X_RST;
            plane_y_reg <= PLANE_Y_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_POS_X:   pos_x_reg   <= cfg_data;
                REG_POS_Y:   pos_y_reg   <= cfg_data;
                REG_DIR_X:   dir_x_reg   <= cfg_data[VEC_W-1:0];
                REG_DIR_Y:   dir_y_reg   <= cfg_data[VEC_W-1:0];
                REG_PLANE_X: plane_x_reg <= cfg_data[VEC_W-1:0];
                REG_PLANE_Y: plane_y_reg <= cfg_data[VEC_W-1:0];
                default: ;
            endcase
        end
    end

    // wall map
    always_comb
    begin
        take_x  = sdx_reg < sdy_reg;
        mx_step = mx_reg + (rx_reg[RAY_W-1] ? {(MAP_BITS+1){1'b1}} : 7'd1);
        my_step = my_reg + (ry_reg[RAY_W-1] ? {(MAP_BITS+1){1'b1}} : 7'd1);
        raddr   = take_x ? {mx_step[MAP_BITS-1:0], my_reg[MAP_BITS-1:0]}
                         : {mx_reg[MAP_BITS-1:0], my_step[MAP_BITS-1:0]};
        we      = (cmd.op == OP_CLEAR) || (cmd.op == OP_WRITE);
        waddr   = (cmd.op == OP_CLEAR) ? clr_cnt_reg : {cell_x, cell_y};
    end

    always_ff @(posedge clk)
    begin
        if (we)
            map_mem[waddr] <= (cmd.op == OP_WRITE) ? cell_wall : 1'b0;
        rd_reg <= map_mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (cmd.op == OP_CLEAR)
            clr_cnt_reg <= clr_cnt_reg + ADDR_BITS'(1);
    end

    // shared divider
    assign abs_rx = rx_reg[RAY_W-1] ? RAY_W'(-rx_reg) : rx_reg;
    assign abs_ry = ry_reg[RAY_W-1] ? RAY_W'(-ry_reg) : ry_reg;

    always_comb
    begin
        div_start = (cmd.op == OP_DIVX) || (cmd.op == OP_DIVY) || (cmd.op == OP_DIVH);
        div_dvd   = (cmd.op == OP_DIVH) ? ROWS_Q16 : ONE_SQ;
        priority if (cmd.op == OP_DIVX)
            div_dvs = DIST_W'(abs_rx);
        else if (cmd.op == OP_DIVY)
            div_dvs = DIST_W'(abs_ry);
        else
            div_dvs = perp_reg;
    end

    grc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // arithmetic
    always_comb
    begin
        cam_a     = CAM_MUL * 18'(column_reg);
        cam_b     = 26'({column_reg, 2'b00}) * 26'(FIFTH_Q16);
        cam_sum   = CAM_W'(cam_a) + CAM_W'(cam_b[25:16]) - CAM_W'(1 << FRAC_BITS);
        ax        = rx_reg[RAY_W-1] ? {1'b0, pos_x_reg[FRAC_BITS-1:0]}
                                    : 17'h10000 - {1'b0, pos_x_reg[FRAC_BITS-1:0]};
        ay        = ry_reg[RAY_W-1] ? {1'b0, pos_y_reg[FRAC_BITS-1:0]}
                                    : 17'h10000 - {1'b0, pos_y_reg[FRAC_BITS-1:0]};
        sx_prod   = 41'(ax) * 41'(ddx_reg);
        sy_prod   = 41'(ay) * 41'(ddy_reg);
        perp_diff = side_reg ? sdy_reg - SD_W'(ddy_reg) : sdx_reg - SD_W'(ddx_reg);
        wall_lo   = (side_reg ? pos_x_reg[FRAC_BITS-1:0] : pos_y_reg[FRAC_BITS-1:0])
                    + wprod_reg[2*FRAC_BITS-1:FRAC_BITS];
        tex       = wall_lo[FRAC_BITS-1:FRAC_BITS-TEX_W];
        if ((!side_reg && !rx_reg[RAY_W-1] && rx_reg != '0) ||
            (side_reg && ry_reg[RAY_W-1]))
            tex = ~tex;
        half      = lh_reg[LH_W-1:1];
        if (half >= 15'(HALF_ROWS))
        begin
            ds = '0;
            de = LAST_ROW;
        end
        else
        begin
            ds = HALF_ROWS - half[ROW_W-1:0];
            de = HALF_ROWS + half[ROW_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            steps_reg <= '0;
        else if (cmd.op == OP_SIDE)
            steps_reg <= '0;
        else if (cmd.op == OP_STEP)
            steps_reg <= steps_reg + STEP_W'(1);
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                column_reg <= column;
                lost_reg   <= 1'b0;
            end
            OP_CAM:  cam_reg <= $signed(cam_sum);
            OP_RMUL:
            begin
                prx_reg <= plane_x_reg * cam_reg;
                pry_reg <= plane_y_reg * cam_reg;
            end
            OP_RAY:
            begin
                rx_reg <= RAY_W'(dir_x_reg) + prx_reg[FRAC_BITS+RAY_W-1:FRAC_BITS];
                ry_reg <= RAY_W'(dir_y_reg) + pry_reg[FRAC_BITS+RAY_W-1:FRAC_BITS];
            end
            OP_STX:  ddx_reg <= (div_q[DVD_W-1:DIST_W] != '0) ? '1 : div_q[DIST_W-1:0];
            OP_STY:  ddy_reg <= (div_q[DVD_W-1:DIST_W] != '0) ? '1 : div_q[DIST_W-1:0];
            OP_SIDE:
            begin
                sdx_reg <= SD_W'(sx_prod[40:FRAC_BITS]);
                sdy_reg <= SD_W'(sy_prod[40:FRAC_BITS]);
                mx_reg  <= {1'b0, pos_x_reg[POS_W-1:FRAC_BITS]};
                my_reg  <= {1'b0, pos_y_reg[POS_W-1:FRAC_BITS]};
            end
            OP_STEP:
            begin
                if (take_x)
                begin
                    sdx_reg  <= sdx_reg + SD_W'(ddx_reg);
                    mx_reg   <= mx_step;
                    side_reg <= 1'b0;
                end
                else
                begin
                    sdy_reg  <= sdy_reg + SD_W'(ddy_reg);
                    my_reg   <= my_step;
                    side_reg <= 1'b1;
                end
            end
            OP_LOST: lost_reg <= 1'b1;
            OP_PERP: perp_reg <= (perp_diff[SD_W-1:DIST_W] != '0) ? '1
                                                                 : perp_diff[DIST_W-1:0];
            OP_STH:  lh_reg <= (div_q[DVD_W-1:LH_W] != '0) ? '1 : div_q[LH_W-1:0];
            OP_WMUL: wprod_reg <= $signed({1'b0, perp_reg}) * (side_reg ? rx_reg : ry_reg);
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.op == OP_FINISH)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_FINISH)
        begin
            column_out <= column_reg;
            out_of_map <= lost_reg;
            if (lost_reg)
            begin
                hit_side      <= 1'b0;
                perp_dist_q16 <= '0;
                slice_height  <= '0;
                row_top       <= '0;
                row_bottom    <= '0;
                tex_column    <= '0;
                hit_x         <= '0;
                hit_y         <= '0;
            end
            else
            begin
                hit_side      <= side_reg;
                perp_dist_q16 <= perp_reg;
                slice_height  <= lh_reg;
                row_top       <= ds;
                row_bottom    <= de;
                tex_column    <= tex;
                hit_x         <= mx_reg[MAP_BITS-1:0];
                hit_y         <= my_reg[MAP_BITS-1:0];
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign status.clr_done = &clr_cnt_reg;
    assign status.div_busy = div_busy;
    assign status.at_limit = steps_reg[STEP_W-1];
    assign status.off_map  = mx_reg[MAP_BITS] | my_reg[MAP_BITS];
    assign status.wall     = rd_reg;
    assign status.out_busy = out_valid_reg & ~out_ready;

endmodule

// ===== hw/rtl/grc_ctrl.sv =====
// Controller state machine sequencing map clearing, cell writes, setup, DDA walk and result load.
`timescale 1ns / 1ps
module grc_ctrl
    import grc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_kind,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_CAM, S_RMUL, S_RAY, S_DX, S_DXW, S_DY, S_DYW,
        S_SIDE, S_STEP, S_CHECK, S_PERP, S_DH, S_DHW, S_WMUL, S_FIN
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NOP;
        in_ready   = (state_reg == S_IDLE);
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.op = OP_CLEAR;
                if (status.clr_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_kind)
                    begin
                        cmd.op     = OP_LOAD;
                        state_next = S_CAM;
                    end
                    else
                        cmd.op = OP_WRITE;
                end
            end
            S_CAM:
            begin
                cmd.op     = OP_CAM;
                state_next = S_RMUL;
            end
            S_RMUL:
            begin
                cmd.op     = OP_RMUL;
                state_next = S_RAY;
            end
            S_RAY:
            begin
                cmd.op     = OP_RAY;
                state_next = S_DX;
            end
            S_DX:
            begin
                cmd.op     = OP_DIVX;
                state_next = S_DXW;
            end
            S_DXW:
            begin
                if (!status.div_busy)
                begin
                    cmd.op     = OP_STX;
                    state_next = S_DY;
                end
            end
            S_DY:
            begin
                cmd.op     = OP_DIVY;
                state_next = S_DYW;
            end
            S_DYW:
            begin
                if (!status.div_busy)
                begin
                    cmd.op     = OP_STY;
                    state_next = S_SIDE;
                end
            end
            S_SIDE:
            begin
                cmd.op     = OP_SIDE;
                state_next = S_STEP;
            end
            S_STEP:
            begin
                if (status.at_limit)
                begin
                    cmd.op     = OP_LOST;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.op     = OP_STEP;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                priority if (status.off_map)
                begin
                    cmd.op     = OP_LOST;
                    state_next = S_FIN;
                end
                else if (status.wall)
                    state_next = S_PERP;
                else
                    state_next = S_STEP;
            end
            S_PERP:
            begin
                cmd.op     = OP_PERP;
                state_next = S_DH;
            end
            S_DH:
            begin
                cmd.op     = OP_DIVH;
                state_next = S_DHW;
            end
            S_DHW:
            begin
                if (!status.div_busy)
                begin
                    cmd.op     = OP_STH;
                    state_next = S_WMUL;
                end
            end
            S_WMUL:
            begin
                cmd.op     = OP_WMUL;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!status.out_busy)
                begin
                    cmd.op     = OP_FINISH;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

endmodule
